/* src/crrm_pkg.sv */
// Shared constants, codes and control types of the chained range remap core.
package crrm_pkg;

  // Default configuration
  localparam int NumStagesDef       = 7;
  localparam int EntriesPerStageDef = 64;
  localparam int ValueBitsDef       = 32;

  // Port field widths
  localparam int FieldW    = 32;
  localparam int ModeW     = 2;
  localparam int StageW    = 3;
  localparam int STdataW   = 4 * FieldW;
  localparam int STuserW   = ModeW + StageW;
  localparam int MTdataW   = 2 * FieldW;
  localparam int MTuserW   = 1;

  // Item kinds
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd0;
  localparam logic [ModeW-1:0] MODE_LOAD  = 2'd1;
  localparam logic [ModeW-1:0] MODE_XLATE = 2'd2;

  // Sequencer to evaluator
  typedef struct packed {
    logic start;      // restart the stage walk from init value
    logic entry_vld;  // memory read data is valid this cycle
  } ev_ctrl_t;

  // Evaluator to sequencer
  typedef struct packed {
    logic busy;       // entries still in flight
    logic sat;        // some range entry of this stage saturated
  } ev_stat_t;

endpackage

/* src/chained_range_remap_min_core.sv */
// Top level: chained range remap tables with running minimum over translated values.
// Clear and load items are accepted back to back.
// A translate item walks every stage in order, reading the entries the stage holds one per cycle
// through the single table read port; no further item is accepted until its result has been
// loaded into the output register.
// Reset empties every stage count, sets the minimum to all ones; table memory is not cleared.
module chained_range_remap_min_core #(
  parameter int NUM_STAGES        = crrm_pkg::NumStagesDef,
  parameter int ENTRIES_PER_STAGE = crrm_pkg::EntriesPerStageDef,
  parameter int VALUE_BITS        = crrm_pkg::ValueBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // dest_start, src_start, span_length, query_value (low to high)
  input  logic [crrm_pkg::STdataW-1:0]   s_axis_tdata,
  // mode, stage (low to high)
  input  logic [crrm_pkg::STuserW-1:0]   s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // location, running_minimum (low to high)
  output logic [crrm_pkg::MTdataW-1:0]   m_axis_tdata,
  // overflow_flag
  output logic [crrm_pkg::MTuserW-1:0]   m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready
);
  import crrm_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int S     = NUM_STAGES;
  localparam int E     = ENTRIES_PER_STAGE;
  localparam int DEPTH = S * E;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (S > 1) ? $clog2(S) : 1;
  localparam int CW    = $clog2(E + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q [S];
  logic [SW-1:0] stage_q;
  logic [CW-1:0] k_q;
  logic [VB-1:0] v_q;
  logic          ovf_q;
  logic [VB-1:0] least_q;
  logic          rd_vld_q;
  logic          out_vld_q;
  logic [VB-1:0] loc_q, min_q;
  logic          out_ovf_q;

  // Input field unpacking
  logic [ModeW-1:0]  in_mode;
  logic [StageW-1:0] in_stage;
  logic [VB-1:0]     in_dest, in_src, in_span, in_query;
  logic              in_acc;
  logic [SW-1:0]     ld_stage;
  logic              ld_ok;

  assign in_mode  = s_axis_tuser[ModeW-1:0];
  assign in_stage = s_axis_tuser[ModeW+StageW-1:ModeW];
  assign in_dest  = VB'(s_axis_tdata[FieldW-1:0]);
  assign in_src   = VB'(s_axis_tdata[2*FieldW-1:FieldW]);
  assign in_span  = VB'(s_axis_tdata[3*FieldW-1:2*FieldW]);
  assign in_query = VB'(s_axis_tdata[4*FieldW-1:3*FieldW]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ld_stage      = SW'(in_stage);
  // Drop loads to a stage that does not exist or is already full
  assign ld_ok         = (int'(in_stage) < S) && (cnt_q[ld_stage] < CW'(E));

  // Table memory access
  logic                ram_we, rd_en;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [3*VB-1:0]     ram_rdata;

  assign ram_we    = in_acc && (in_mode == MODE_LOAD) && ld_ok;
  assign ram_waddr = AW'(ld_stage) * AW'(E) + AW'(cnt_q[ld_stage]);
  assign rd_en     = (state_q == ST_WALK) && (k_q < cnt_q[stage_q]);
  assign ram_raddr = AW'(stage_q) * AW'(E) + AW'(k_q);

  crrm_ram #(
    .WIDTH (3 * VB),
    .DEPTH (DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_span, in_src, in_dest}),
    .re_i    (rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry evaluator
  ev_ctrl_t      ev_ctrl;
  ev_stat_t      ev_stat;
  logic [VB-1:0] ev_res;
  logic [VB-1:0] ev_init;
  logic          commit;

  assign commit          = (state_q == ST_DRAIN) && !ev_stat.busy;
  assign ev_ctrl.start   = (in_acc && (in_mode == MODE_XLATE)) || commit;
  assign ev_ctrl.entry_vld = rd_vld_q;
  assign ev_init         = (state_q == ST_IDLE) ? in_query : ev_res;

  crrm_eval #(
    .VALUE_BITS (VB)
  ) u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ev_ctrl),
    .v_i     (v_q),
    .init_i  (ev_init),
    .entry_i (ram_rdata),
    .res_o   (ev_res),
    .stat_o  (ev_stat)
  );

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  // Sequencer, stage counts, running minimum and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      for (int i = 0; i < S; i++) begin
        cnt_q[i] <= '0;
      end
      stage_q   <= '0;
      k_q       <= '0;
      ovf_q     <= 1'b0;
      least_q   <= {VB{1'b1}};
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      v_q       <= '0;
      loc_q     <= '0;
      min_q     <= '0;
      out_ovf_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      // Load a finished item into the output register, or drop the one just taken
      if ((state_q == ST_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_mode)
              MODE_CLEAR: begin
                for (int i = 0; i < S; i++) begin
                  cnt_q[i] <= '0;
                end
                least_q <= {VB{1'b1}};
              end
              MODE_LOAD: begin
                if (ld_ok) begin
                  cnt_q[ld_stage] <= cnt_q[ld_stage] + 1'b1;
                end
              end
              MODE_XLATE: begin
                v_q     <= in_query;
                stage_q <= '0;
                k_q     <= '0;
                ovf_q   <= 1'b0;
                state_q <= ST_WALK;
              end
              default: begin
                // Unused kind: drop the item
              end
            endcase
          end
        end
        ST_WALK: begin
          // Issue one entry read per cycle until the stage is exhausted
          if (rd_en) begin
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Wait for in-flight entries, then hand the stage result on
          if (commit) begin
            if (ev_stat.sat && (ev_res == {VB{1'b1}})) begin
              ovf_q <= 1'b1;
            end
            v_q <= ev_res;
            k_q <= '0;
            if (stage_q == SW'(S - 1)) begin
              state_q <= ST_DONE;
            end else begin
              stage_q <= stage_q + 1'b1;
              state_q <= ST_WALK;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            loc_q     <= v_q;
            out_ovf_q <= ovf_q;
            if (v_q < least_q) begin
              least_q <= v_q;
              min_q   <= v_q;
            end else begin
              min_q   <= least_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {FieldW'(min_q), FieldW'(loc_q)};
  assign m_axis_tuser  = out_ovf_q;

  // Assertions
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ev_stat.busy)
    else $error("evaluator busy while accepting items");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (k_q < CW'(E)))
    else $error("table read beyond stage capacity");

  a_min_le_loc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (min_q <= loc_q))
    else $error("running minimum above reported location");

  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!rd_vld_q && !rd_en))
    else $error("stage committed with reads in flight");

endmodule

/* src/crrm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module crrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/crrm_eval.sv */
// Two-step entry evaluator: compare one table entry, then fold it into the stage result.
module crrm_eval #(
  parameter int VALUE_BITS = crrm_pkg::ValueBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  crrm_pkg::ev_ctrl_t        ctrl_i,
  input  logic [VALUE_BITS-1:0]     v_i,
  input  logic [VALUE_BITS-1:0]     init_i,
  input  logic [3*VALUE_BITS-1:0]   entry_i,   // {span, src, dest}
  output logic [VALUE_BITS-1:0]     res_o,
  output crrm_pkg::ev_stat_t        stat_o
);
  import crrm_pkg::*;

  localparam int VB = VALUE_BITS;

  logic [VB-1:0] dst, src, span;
  logic [VB:0]   lim;
  logic          eq, rng;
  logic [VB-1:0] diff;
  logic [VB:0]   sum;

  logic          p2_vld_q, p2_eq_q, p2_rng_q;
  logic [VB-1:0] p2_dst_q, p2_diff_q;
  logic          hit_q, sat_q;
  logic [VB-1:0] res_q;

  assign dst  = entry_i[VB-1:0];
  assign src  = entry_i[2*VB-1:VB];
  assign span = entry_i[3*VB-1:2*VB];

  // Range end is formed one bit wider so it never wraps
  assign lim  = {1'b0, src} + {1'b0, span};
  assign eq   = (v_i == src);
  assign rng  = (src < v_i) && (lim > {1'b0, v_i});
  assign diff = v_i - src;
  assign sum  = {1'b0, p2_dst_q} + {1'b0, p2_diff_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      p2_vld_q <= ctrl_i.entry_vld;
      if (ctrl_i.start) begin
        hit_q <= 1'b0;
        sat_q <= 1'b0;
      end else if (p2_vld_q && !hit_q) begin
        if (p2_eq_q) begin
          hit_q <= 1'b1;
        end else if (p2_rng_q && sum[VB]) begin
          sat_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p2_eq_q   <= eq;
    p2_rng_q  <= rng;
    p2_dst_q  <= dst;
    p2_diff_q <= diff;
    if (ctrl_i.start) begin
      res_q <= init_i;
    end else if (p2_vld_q && !hit_q) begin
      // First exact start match ends the stage; later range hits override earlier ones
      if (p2_eq_q) begin
        res_q <= p2_dst_q;
      end else if (p2_rng_q) begin
        res_q <= sum[VB] ? {VB{1'b1}} : sum[VB-1:0];
      end
    end
  end

  assign res_o       = res_q;
  assign stat_o.busy = ctrl_i.entry_vld | p2_vld_q;
  assign stat_o.sat  = sat_q;

endmodule

/* verif/tb_chained_range_remap_min_core.sv */
// Self-checking testbench for the chained range remap core with running minimum.
module tb_chained_range_remap_min_core;
  import crrm_pkg::*;

  localparam int STAGES = NumStagesDef;
  localparam int DEPTH = EntriesPerStageDef;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam bit [32:0] VALUE_MAX = 33'h0_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 500;

  typedef struct packed {
    bit [31:0] location;
    bit [31:0] least;
    bit        ovf;
  } remap_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [STdataW-1:0]   s_axis_tdata = '0;
  logic [STuserW-1:0]   s_axis_tuser = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [MTdataW-1:0]   m_axis_tdata;
  logic [MTuserW-1:0]   m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  // Shadow copy of the tables and the running minimum
  bit [31:0] dst_tab [STAGES][DEPTH];
  bit [31:0] src_tab [STAGES][DEPTH];
  bit [31:0] span_tab [STAGES][DEPTH];
  int        stage_fill [STAGES];
  bit [31:0] least_loc;

  remap_result_t pending_results[$];
  remap_result_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int n_clears = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_errors = 0;

  chained_range_remap_min_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: hold off for a counted stretch when asked, else stall at random
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Walk a value through every stage; flag a stage that ends on a saturated value
  function automatic bit [31:0] walk_stages(input bit [31:0] query, output bit sat_seen);
    bit [32:0] v;
    bit [32:0] nv;
    bit [32:0] sum;
    bit [32:0] src;
    bit [32:0] reach;
    bit        stage_sat;
    bit        hit;
    v = {1'b0, query};
    sat_seen = 1'b0;
    for (int s = 0; s < STAGES; s++) begin
      nv = v;
      stage_sat = 1'b0;
      hit = 1'b0;
      for (int k = 0; k < stage_fill[s] && !hit; k++) begin
        src = {1'b0, src_tab[s][k]};
        // the range end is formed one bit wider so it never wraps
        reach = src + {1'b0, span_tab[s][k]};
        if (v == src) begin
          // first exact start match in load order wins outright
          nv = {1'b0, dst_tab[s][k]};
          hit = 1'b1;
        end else if (src < v && reach > v) begin
          // later range matches override earlier ones
          sum = {1'b0, dst_tab[s][k]} + (v - src);
          if (sum > VALUE_MAX) begin
            sum = VALUE_MAX;
            stage_sat = 1'b1;
          end
          nv = sum;
        end
      end
      if (stage_sat && nv == VALUE_MAX) sat_seen = 1'b1;
      v = nv;
    end
    return v[31:0];
  endfunction

  // Update the shadow state for one accepted item and queue its result, if any
  function automatic void track_item(input bit [1:0] mode, input bit [2:0] stage,
                                     input bit [31:0] dst, input bit [31:0] src,
                                     input bit [31:0] span, input bit [31:0] qv);
    remap_result_t r;
    bit            sat;
    case (mode)
      MODE_CLEAR: begin
        foreach (stage_fill[s]) stage_fill[s] = 0;
        least_loc = '1;
        n_clears++;
      end
      MODE_LOAD: begin
        // drop loads to a missing stage or a full one
        if (stage < STAGES && stage_fill[stage] < DEPTH) begin
          dst_tab[stage][stage_fill[stage]] = dst;
          src_tab[stage][stage_fill[stage]] = src;
          span_tab[stage][stage_fill[stage]] = span;
          stage_fill[stage]++;
        end
        n_loads++;
      end
      MODE_XLATE: begin
        r.location = walk_stages(qv, sat);
        if (r.location < least_loc) least_loc = r.location;
        r.least = least_loc;
        r.ovf = sat;
        pending_results.insert(pending_results.size(), r);
        n_queries++;
      end
      default: ;
    endcase
  endfunction

  // Offer one item at the falling edge, hold it until the handshake completes
  task automatic send_item(input bit [1:0] mode, input bit [2:0] stage, input bit [31:0] dst,
                           input bit [31:0] src, input bit [31:0] span, input bit [31:0] qv);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = {qv, span, src, dst};
    s_axis_tuser = {stage, mode};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_item(mode, stage, dst, src, span, qv);
  endtask

  task automatic send_clear();
    send_item(MODE_CLEAR, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_load(input bit [2:0] stage, input bit [31:0] dst, input bit [31:0] src,
                           input bit [31:0] span);
    send_item(MODE_LOAD, stage, dst, src, span, $urandom);
  endtask

  task automatic send_query(input bit [31:0] qv);
    send_item(MODE_XLATE, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, qv);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got location %h minimum %h flag %b",
                 $time, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0]);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (m_axis_tdata[31:0] !== want.location) begin
          $display("%0t: location mismatch: expected %h, got %h", $time, want.location,
                   m_axis_tdata[31:0]);
          n_errors++;
        end
        if (m_axis_tdata[63:32] !== want.least) begin
          $display("%0t: running minimum mismatch: expected %h, got %h", $time, want.least,
                   m_axis_tdata[63:32]);
          n_errors++;
        end
        if (m_axis_tuser[0] !== want.ovf) begin
          $display("%0t: overflow flag mismatch: expected %b, got %b", $time, want.ovf,
                   m_axis_tuser[0]);
          n_errors++;
        end
      end
    end
  end

  // Overlaps, exact starts, zero spans, saturation, wide range ends, dropped items
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_query(32'd0);
    send_query(32'hFFFF_FFFF);
    send_load(3'd0, 32'd100, 32'd10, 32'd5);
    send_load(3'd0, 32'd200, 32'd12, 32'd10);
    send_load(3'd0, 32'd300, 32'd10, 32'd0);
    send_load(3'd1, 32'd7, 32'd300, 32'd0);
    send_load(3'd6, 32'hFFFF_FFF0, 32'd1000, 32'hFFFF_FFFF);
    send_load(3'd2, 32'd5, 32'hFFFF_FFF0, 32'h20);
    send_load(3'd7, 32'd1, 32'd13, 32'd3);
    send_item(MODE_UNUSED, 3'd0, 32'd5, 32'd13, 32'd100, 32'd13);
    send_query(32'd10);
    send_query(32'd13);
    send_query(32'd12);
    send_query(32'd11);
    send_query(32'd300);
    send_query(32'd301);
    send_query(32'd1040);
    send_query(32'd1015);
    send_query(32'hFFFF_FFFF);
    send_clear();
    send_query(32'd5);
    drop_valid();
  endtask

  // Fill one stage to capacity and check that the extra entry is dropped
  task automatic test_full_stage();
    send_clear();
    for (int k = 0; k < DEPTH; k++) send_load(3'd3, 32'd1000 + k, 32'd5000 + 2 * k, 32'd1);
    send_load(3'd3, 32'd9, 32'd7777, 32'd0);
    send_query(32'd5000);
    send_query(32'd5126);
    send_query(32'd5001);
    send_query(32'd7777);
    drop_valid();
  endtask

  // Hold the receiver off while queries keep coming so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    send_clear();
    send_load(3'd0, 32'd50, 32'd1, 32'd40);
    send_load(3'd4, 32'd900, 32'd60, 32'd10);
    while (pending_results.size() != 0) @(posedge clk_i);
    hold_cycles = 800;
    for (int k = 0; k < 40; k++) send_query($urandom_range(0, 80));
    drop_valid();
  endtask

  function automatic bit [31:0] random_value(input int kind);
    case (kind)
      0, 1: return $urandom_range(0, 255);
      2: return $urandom;
      default: return ($urandom_range(0, 1) != 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
                                                  : $urandom_range(0, 255);
    endcase
  endfunction

  function automatic bit [31:0] random_span(input int kind);
    case ($urandom_range(0, 9))
      0, 1: return 32'd0;
      2: return $urandom;
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return (kind == 2) ? $urandom_range(1, 1 << 20) : $urandom_range(1, 64);
    endcase
  endfunction

  // Mostly well-formed clear / load / query sequences over one value domain, some noise
  task automatic run_random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int        sent;
    int        kind;
    int        n_load;
    bit [1:0]  mode;
    bit [2:0]  stage;
    bit [31:0] pool[$];
    bit [31:0] d;
    bit [31:0] s;
    bit [31:0] q;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        mode = 2'($urandom_range(0, 3));
        stage = 3'($urandom_range(0, 7));
        send_item(mode, stage, $urandom, $urandom, $urandom, $urandom);
        // unused kinds and loads to a missing stage do not count
        if (!(mode == MODE_UNUSED || (mode == MODE_LOAD && stage >= STAGES))) sent++;
      end else begin
        kind = $urandom_range(0, 3);
        pool.delete();
        if ($urandom_range(0, 3) != 0) begin
          send_clear();
          sent++;
        end
        for (int st = 0; st < STAGES; st++) begin
          n_load = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 4);
          repeat (n_load) begin
            // chain stages: reuse earlier starts and destinations as new sources
            s = (pool.size() != 0 && $urandom_range(0, 1) != 0)
                ? pool[$urandom_range(0, pool.size() - 1)] : random_value(kind);
            d = random_value(kind);
            send_load(3'(st), d, s, random_span(kind));
            pool.insert(pool.size(), s);
            pool.insert(pool.size(), d);
            sent++;
          end
        end
        repeat ($urandom_range(3, 10)) begin
          if (pool.size() != 0 && $urandom_range(0, 2) != 0)
            q = pool[$urandom_range(0, pool.size() - 1)] + 32'($urandom_range(0, 8)) - 32'd4;
          else
            q = random_value(kind);
          send_query(q);
          sent++;
        end
      end
    end
    drop_valid();
  endtask

  initial begin
    foreach (stage_fill[s]) stage_fill[s] = 0;
    least_loc = '1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_full_stage();
    test_output_backpressure();
    run_random_traffic(180, 32, 58);
    run_random_traffic(180, 58, 32);
    run_random_traffic(180, 0, 0);

    // Drain outstanding results, then allow for one full-length walk
    recv_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d clears, %0d loads, %0d queries sent; %0d results compared.",
             n_clears, n_loads, n_queries, n_checked);
    $display("Covered overlap, exact start, zero span, saturation, full stage and stalls.");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
